@@ rtl/pmat_pkg.sv @@
// Shared types and constants of the power monitor averaging and trip unit.
`default_nettype none

package pmat_pkg;

    // Samples averaged per result word
    localparam int SAMPLES_PER_AVERAGE = 5;

    // Field widths
    localparam int SAMPLE_W   = 8;
    localparam int CUR_W      = 14;
    localparam int VOL_W      = 15;
    localparam int PWR_W      = 18;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 18;

    localparam int SAMPLE_MAX = 255;

    // Scale factors in lowest terms
    // current: 13905/255 mA per count = 927/17
    // voltage: 33063/510 dV per count = 11021/170
    localparam int CUR_NUM = 927;
    localparam int CUR_DEN = 17;
    localparam int VOL_NUM = 11021;
    localparam int VOL_DEN = 170;
    localparam int PWR_DEN = 1000;

    // Register reset values
    localparam logic [CUR_W-1:0] CUR_FLOOR_RST = CUR_W'(80);
    localparam logic [VOL_W-1:0] VOL_FLOOR_RST = VOL_W'(150);
    localparam logic [PWR_W-1:0] PWR_LIMIT_RST = PWR_W'(6000);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CUR_FLOOR = 2'd0,
        CFG_VOL_FLOOR = 2'd1,
        CFG_PWR_LIMIT = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [SAMPLE_W-1:0] current_sample;
        logic [SAMPLE_W-1:0] voltage_sample;
    } t_in_word;

    typedef struct packed {
        logic [VOL_W-1:0] voltage_dv;
        logic [CUR_W-1:0] current_ma;
        logic [PWR_W-1:0] power_dw;
        logic             tripped;
    } t_out_word;

    typedef struct packed {
        logic [CUR_W-1:0] current_ma;
        logic [VOL_W-1:0] voltage_dv;
    } t_avg_word;

endpackage

`default_nettype wire

@@ rtl/pmat_div_const.sv @@
// Two-stage divide of an unsigned word by a constant: reciprocal multiply, then one correction.
`default_nettype none

module pmat_div_const #(
    parameter int NUM_W = 27,
    parameter int DEN   = 340,
    parameter int Q_W   = 15
) (
    input  wire logic             i_clk,
    input  wire logic             i_en,
    input  wire logic [NUM_W-1:0] i_num,
    output logic      [Q_W-1:0]   o_q
);

    // floor(2^NUM_W / DEN): estimate is never high and at most one low
    localparam longint unsigned RECIP   = (longint'(1) << NUM_W) / DEN;
    localparam int              RECIP_W = $clog2(RECIP + 1);
    localparam int              PROD_W  = NUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_V = RECIP_W'(RECIP);
    localparam logic [NUM_W-1:0]   DEN_V   = NUM_W'(DEN);

    logic [PROD_W-1:0] prod;
    logic [Q_W-1:0]    n_q0;
    logic [NUM_W-1:0]  r_num;
    logic [Q_W-1:0]    r_q0;
    logic [NUM_W-1:0]  back;
    logic [NUM_W-1:0]  rem;
    logic [Q_W-1:0]    n_q;
    logic [Q_W-1:0]    r_q;

    assign prod = PROD_W'(i_num) * PROD_W'(RECIP_V);
    assign n_q0 = Q_W'(prod >> NUM_W);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num <= i_num;
            r_q0  <= n_q0;
        end
    end

    // bump the estimate when the remainder still holds one divisor
    assign back = NUM_W'(r_q0) * DEN_V;
    assign rem  = r_num - back;
    assign n_q  = r_q0 + Q_W'(rem >= DEN_V);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;

endmodule

`default_nettype wire

@@ rtl/pmat_accum.sv @@
// Per-sample current floor test and running sums of raw counts over one averaging window.
`default_nettype none

module pmat_accum #(
    parameter  int N     = pmat_pkg::SAMPLES_PER_AVERAGE,
    localparam int SUM_W = $clog2(pmat_pkg::SAMPLE_MAX * N + 1)
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_en,
    input  wire logic                         i_valid,
    input  wire pmat_pkg::t_in_word           i_word,
    input  wire logic [pmat_pkg::CUR_W-1:0]   i_cur_floor,
    output logic                              o_valid,
    output logic      [SUM_W-1:0]             o_csum,
    output logic      [SUM_W-1:0]             o_vsum
);

    localparam int CNT_W = (N > 1) ? $clog2(N) : 1;
    localparam int FT_W  = pmat_pkg::CUR_W + $clog2(pmat_pkg::CUR_DEN + 1);

    logic [CNT_W-1:0] r_cnt;
    logic [SUM_W-1:0] r_csum;
    logic [SUM_W-1:0] r_vsum;
    logic             r_valid;
    logic [SUM_W-1:0] r_out_csum;
    logic [SUM_W-1:0] r_out_vsum;

    logic [FT_W-1:0]                    smp_lhs;
    logic [FT_W-1:0]                    smp_rhs;
    logic [pmat_pkg::SAMPLE_W-1:0]      cur_smp;
    logic [SUM_W-1:0]                   add_c;
    logic [SUM_W-1:0]                   add_v;
    logic                               last;

    // count * 927 < floor * 17 is the exact test count * 13905/255 < floor
    assign smp_lhs = FT_W'(i_word.current_sample) * FT_W'(pmat_pkg::CUR_NUM);
    assign smp_rhs = FT_W'(i_cur_floor) * FT_W'(pmat_pkg::CUR_DEN);
    assign cur_smp = (smp_lhs < smp_rhs) ? '0 : i_word.current_sample;

    assign add_c = r_csum + SUM_W'(cur_smp);
    assign add_v = r_vsum + SUM_W'(i_word.voltage_sample);
    assign last  = (r_cnt == CNT_W'(N - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_csum  <= '0;
            r_vsum  <= '0;
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid && last;
            if (i_valid) begin
                if (last) begin
                    r_cnt  <= '0;
                    r_csum <= '0;
                    r_vsum <= '0;
                end else begin
                    r_cnt  <= r_cnt + CNT_W'(1);
                    r_csum <= add_c;
                    r_vsum <= add_v;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && i_valid && last) begin
            r_out_csum <= add_c;
            r_out_vsum <= add_v;
        end
    end

    assign o_valid = r_valid;
    assign o_csum  = r_out_csum;
    assign o_vsum  = r_out_vsum;

endmodule

`default_nettype wire

@@ rtl/pmat_average.sv @@
// Scaled, rounded averages of current and voltage with the floor tests on the exact values.
`default_nettype none

module pmat_average #(
    parameter  int N     = pmat_pkg::SAMPLES_PER_AVERAGE,
    localparam int SUM_W = $clog2(pmat_pkg::SAMPLE_MAX * N + 1)
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_en,
    input  wire logic                         i_valid,
    input  wire logic [SUM_W-1:0]             i_csum,
    input  wire logic [SUM_W-1:0]             i_vsum,
    input  wire logic [pmat_pkg::CUR_W-1:0]   i_cur_floor,
    input  wire logic [pmat_pkg::VOL_W-1:0]   i_vol_floor,
    output logic                              o_valid,
    output pmat_pkg::t_avg_word               o_avg
);

    // round half up: (2*sum*NUM + DEN*N) / (2*DEN*N)
    localparam int DC   = 2 * pmat_pkg::CUR_DEN * N;
    localparam int DV   = 2 * pmat_pkg::VOL_DEN * N;
    localparam int NC_W = $clog2(2 * pmat_pkg::SAMPLE_MAX * N * pmat_pkg::CUR_NUM
                                 + pmat_pkg::CUR_DEN * N + 1);
    localparam int NV_W = $clog2(2 * pmat_pkg::SAMPLE_MAX * N * pmat_pkg::VOL_NUM
                                 + pmat_pkg::VOL_DEN * N + 1);
    localparam int FC_W = $clog2((2 ** pmat_pkg::CUR_W) * pmat_pkg::CUR_DEN * N);
    localparam int FV_W = $clog2((2 ** pmat_pkg::VOL_W) * pmat_pkg::VOL_DEN * N);

    logic [NC_W-1:0] n_numc;
    logic [NV_W-1:0] n_numv;
    logic [FC_W-1:0] fc_lhs;
    logic [FC_W-1:0] fc_rhs;
    logic [FV_W-1:0] fv_lhs;
    logic [FV_W-1:0] fv_rhs;

    logic [NC_W-1:0] r_numc;
    logic [NV_W-1:0] r_numv;
    logic [2:0]      r_zc;
    logic [2:0]      r_zv;
    logic [2:0]      r_v;

    logic [pmat_pkg::CUR_W-1:0] qc;
    logic [pmat_pkg::VOL_W-1:0] qv;

    assign n_numc = NC_W'(i_csum) * NC_W'(2 * pmat_pkg::CUR_NUM)
                  + NC_W'(pmat_pkg::CUR_DEN * N);
    assign n_numv = NV_W'(i_vsum) * NV_W'(2 * pmat_pkg::VOL_NUM)
                  + NV_W'(pmat_pkg::VOL_DEN * N);

    // exact floor tests with the common factors taken out
    assign fc_lhs = FC_W'(i_csum) * FC_W'(pmat_pkg::CUR_NUM);
    assign fc_rhs = FC_W'(i_cur_floor) * FC_W'(pmat_pkg::CUR_DEN * N);
    assign fv_lhs = FV_W'(i_vsum) * FV_W'(pmat_pkg::VOL_NUM);
    assign fv_rhs = FV_W'(i_vol_floor) * FV_W'(pmat_pkg::VOL_DEN * N);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_numc <= n_numc;
            r_numv <= n_numv;
            r_zc   <= {r_zc[1:0], (fc_lhs < fc_rhs)};
            r_zv   <= {r_zv[1:0], (fv_lhs < fv_rhs)};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[1:0], i_valid};
        end
    end

    pmat_div_const #(
        .NUM_W (NC_W),
        .DEN   (DC),
        .Q_W   (pmat_pkg::CUR_W)
    ) u_div_cur (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_num (r_numc),
        .o_q   (qc)
    );

    pmat_div_const #(
        .NUM_W (NV_W),
        .DEN   (DV),
        .Q_W   (pmat_pkg::VOL_W)
    ) u_div_vol (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_num (r_numv),
        .o_q   (qv)
    );

    assign o_valid          = r_v[2];
    assign o_avg.current_ma = r_zc[2] ? '0 : qc;
    assign o_avg.voltage_dv = r_zv[2] ? '0 : qv;

endmodule

`default_nettype wire

@@ rtl/pmat_power.sv @@
// Power from the averaged current and voltage, rounded to tenths of a watt.
`default_nettype none

module pmat_power (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_en,
    input  wire logic                         i_valid,
    input  wire pmat_pkg::t_avg_word          i_avg,
    output logic                              o_valid,
    output pmat_pkg::t_avg_word               o_avg,
    output logic      [pmat_pkg::PWR_W-1:0]   o_pwr
);

    localparam int PROD_W = pmat_pkg::CUR_W + pmat_pkg::VOL_W;
    localparam int NUM_W  = PROD_W + 1;

    logic [PROD_W-1:0]        r_prod;
    logic [NUM_W-1:0]         num;
    pmat_pkg::t_avg_word      r_avg [3];
    logic [2:0]               r_v;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod   <= PROD_W'(i_avg.current_ma) * PROD_W'(i_avg.voltage_dv);
            r_avg[0] <= i_avg;
            r_avg[1] <= r_avg[0];
            r_avg[2] <= r_avg[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[1:0], i_valid};
        end
    end

    // round half up: (2*p + 1000) / 2000
    assign num = {r_prod, 1'b0} + NUM_W'(pmat_pkg::PWR_DEN);

    pmat_div_const #(
        .NUM_W (NUM_W),
        .DEN   (2 * pmat_pkg::PWR_DEN),
        .Q_W   (pmat_pkg::PWR_W)
    ) u_div_pwr (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_num (num),
        .o_q   (o_pwr)
    );

    assign o_valid = r_v[2];
    assign o_avg   = r_avg[2];

endmodule

`default_nettype wire

@@ rtl/power_monitor_average_trip_unit.sv @@
// Top level of the averaging power monitor with over-power trip latch.
//
//  channel | direction | handshake                    | word
//  --------+-----------+------------------------------+------------------------------
//  in      | to block  | i_in_valid / o_in_stall      | i_in_word  (current, voltage)
//  out     | from block| o_out_valid / i_out_stall    | o_out_word (dV, mA, dW, trip)
//  cfg     | to block  | i_cfg_we, i_cfg_idx          | i_cfg_data
//
// One sample word is taken every cycle unless o_in_stall is high; a result word
// follows each word that closes a window of SAMPLES_PER_AVERAGE samples. It passes
// the input register, accumulate, scale, reciprocal divide (estimate and correction),
// product, reciprocal divide (estimate and correction) and output register.
// Synchronous active-low reset clears the sums, the window count, the trip
// latch and the registers to their defaults; the relay is closed after reset.
// The whole pipeline holds only when a finished word waits behind a stalled
// output register; otherwise input words keep flowing while a result waits.
`default_nettype none

module power_monitor_average_trip_unit #(
    parameter int SAMPLES_PER_AVERAGE = pmat_pkg::SAMPLES_PER_AVERAGE
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // sample input
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire pmat_pkg::t_in_word                i_in_word,
    // result output
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output pmat_pkg::t_out_word                    o_out_word,
    // register writes
    input  wire logic                              i_cfg_we,
    input  wire logic [pmat_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [pmat_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int SUM_W = $clog2(pmat_pkg::SAMPLE_MAX * SAMPLES_PER_AVERAGE + 1);

    // configuration registers
    logic [pmat_pkg::CUR_W-1:0] r_cur_floor;
    logic [pmat_pkg::VOL_W-1:0] r_vol_floor;
    logic [pmat_pkg::PWR_W-1:0] r_pwr_limit;

    // input register
    logic                 r_in_valid;
    pmat_pkg::t_in_word   r_in_word;

    // pipeline hand-offs
    logic                 adv;
    logic                 acc_valid;
    logic [SUM_W-1:0]     acc_csum;
    logic [SUM_W-1:0]     acc_vsum;
    logic                 avg_valid;
    pmat_pkg::t_avg_word  avg_word;
    logic                 pwr_valid;
    pmat_pkg::t_avg_word  pwr_avg;
    logic [pmat_pkg::PWR_W-1:0] pwr_dw;

    // output register and trip latch
    logic                 r_out_valid;
    pmat_pkg::t_out_word  r_out_word;
    logic                 r_trip;
    logic                 trip_now;
    logic                 load;

    // ---- register writes; unlisted indexes are dropped ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_floor <= pmat_pkg::CUR_FLOOR_RST;
            r_vol_floor <= pmat_pkg::VOL_FLOOR_RST;
            r_pwr_limit <= pmat_pkg::PWR_LIMIT_RST;
        end else if (i_cfg_we) begin
            unique case (pmat_pkg::t_cfg_idx'(i_cfg_idx))
                pmat_pkg::CFG_CUR_FLOOR: r_cur_floor <= pmat_pkg::CUR_W'(i_cfg_data);
                pmat_pkg::CFG_VOL_FLOOR: r_vol_floor <= pmat_pkg::VOL_W'(i_cfg_data);
                pmat_pkg::CFG_PWR_LIMIT: r_pwr_limit <= pmat_pkg::PWR_W'(i_cfg_data);
                default: ;
            endcase
        end
    end

    // ---- pipeline advance ----
    // Hold everything only if a finished word would land on a stalled full output.
    assign adv        = !(r_out_valid && i_out_stall && pwr_valid);
    assign o_in_stall = !adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (adv) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_in_word <= i_in_word;
        end
    end

    // ---- accumulate raw counts over the window ----
    pmat_accum #(
        .N (SAMPLES_PER_AVERAGE)
    ) u_accum (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (adv),
        .i_valid     (r_in_valid),
        .i_word      (r_in_word),
        .i_cur_floor (r_cur_floor),
        .o_valid     (acc_valid),
        .o_csum      (acc_csum),
        .o_vsum      (acc_vsum)
    );

    // ---- scale and round the averages, apply floors ----
    pmat_average #(
        .N (SAMPLES_PER_AVERAGE)
    ) u_average (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (adv),
        .i_valid     (acc_valid),
        .i_csum      (acc_csum),
        .i_vsum      (acc_vsum),
        .i_cur_floor (r_cur_floor),
        .i_vol_floor (r_vol_floor),
        .o_valid     (avg_valid),
        .o_avg       (avg_word)
    );

    // ---- power in tenths of a watt ----
    pmat_power u_power (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (avg_valid),
        .i_avg   (avg_word),
        .o_valid (pwr_valid),
        .o_avg   (pwr_avg),
        .o_pwr   (pwr_dw)
    );

    // ---- trip latch and output register ----
    // The latch only sets; the relay stays open until reset.
    assign load     = pwr_valid && adv;
    assign trip_now = r_trip || (pwr_dw >= r_pwr_limit);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_trip      <= 1'b0;
        end else begin
            if (load) begin
                r_out_valid <= 1'b1;
                r_trip      <= trip_now;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_word.voltage_dv <= pwr_avg.voltage_dv;
            r_out_word.current_ma <= pwr_avg.current_ma;
            r_out_word.power_dw   <= pwr_dw;
            r_out_word.tripped    <= trip_now;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

`default_nettype wire

@@ rtl/pmat_checker.sv @@
// Port-level checks of the power monitor unit and the bind that attaches them.
`default_nettype none

module pmat_checker (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              o_out_valid,
    input  wire logic                              i_out_stall,
    input  wire pmat_pkg::t_out_word               o_out_word
);

    // remember a shown trip; it must never clear before reset
    logic r_seen_trip;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_trip <= 1'b0;
        end else if (o_out_valid && o_out_word.tripped) begin
            r_seen_trip <= 1'b1;
        end
    end

    a_trip_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && r_seen_trip) |-> o_out_word.tripped)
        else $error("trip latch cleared without reset");

    a_zero_power: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && ((o_out_word.current_ma == '0) || (o_out_word.voltage_dv == '0)))
        |-> (o_out_word.power_dw == '0))
        else $error("nonzero power with zero current or voltage");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result word shown right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_word)))
        else $error("stalled result word dropped or changed");

endmodule

bind power_monitor_average_trip_unit pmat_checker u_pmat_checker (.*);

`default_nettype wire
